// ----- rtl/core/mpq_pkg.sv -----
// shared types and constants of the multi-policy ready queue
package mpq_pkg;

  // fixed width of a process id
  localparam int unsigned PID_WIDTH = 4;

  // operation codes of an input word
  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // dispatch policies
  typedef enum logic [1:0] {
    POL_ROUND_ROBIN = 2'd0,
    POL_FCFS        = 2'd1,
    POL_PRIORITY    = 2'd2,
    POL_SHORTEST    = 2'd3
  } policy_e;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ----- rtl/core/mpq_if.sv -----
// request and response channel interfaces of the ready queue

interface mpq_req_if #(
  parameter int unsigned TIME_WIDTH     = 16,
  parameter int unsigned PRIORITY_WIDTH = 8
);
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [mpq_pkg::PID_WIDTH-1:0]       process_id;
  logic [TIME_WIDTH-1:0]               arrival_tick;
  logic [PRIORITY_WIDTH-1:0]           priority_level;
  logic [TIME_WIDTH-1:0]               run_ticks;

  modport source (
    output valid, op, process_id, arrival_tick, priority_level, run_ticks,
    input  ready
  );
  modport sink (
    input  valid, op, process_id, arrival_tick, priority_level, run_ticks,
    output ready
  );
endinterface

interface mpq_rsp_if #(
  parameter int unsigned COUNT_WIDTH = 5
);
  logic                          valid;
  logic                          ready;
  logic [mpq_pkg::PID_WIDTH-1:0] chosen_id;
  logic                          chosen_valid;
  logic                          queue_empty;
  logic                          queue_overflow;
  logic [COUNT_WIDTH-1:0]        entries_held;

  modport source (
    output valid, chosen_id, chosen_valid, queue_empty, queue_overflow, entries_held,
    input  ready
  );
  modport sink (
    input  valid, chosen_id, chosen_valid, queue_empty, queue_overflow, entries_held,
    output ready
  );
endinterface

// ----- rtl/core/multi_policy_ready_queue.sv -----
// multi-policy ready queue: top level with scan and compaction sequencer
// result: an enqueue word passes through the done state into the output register;
//   a dispatch first scans all n entries held, then shifts the entries after the one taken
// throughput: one word at a time; the next word is accepted when the sequencer is idle,
//   set by the single read port of the entry ram (one entry read per cycle)
// reset: asynchronous, active low; clears count, policy and handshake state,
//   entry ram contents are left as they are
module multi_policy_ready_queue #(
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned TIME_WIDTH     = 16,
  parameter int unsigned PRIORITY_WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  mpq_req_if.sink          req_i,
  mpq_rsp_if.source        rsp_o
);

  // widths derived from the parameters
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = mpq_pkg::PID_WIDTH;
  // entry word layout: {pid, arrival, priority, remaining}
  localparam int unsigned EW = PW + 2 * TIME_WIDTH + PRIORITY_WIDTH;

  // sequencer and bookkeeping
  mpq_pkg::state_e  state_q, state_d;
  mpq_pkg::policy_e policy_q;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;          // index of the entry whose read data arrives now

  // best candidate found so far in a scan
  logic [AW-1:0]             best_idx_q, best_idx_d;
  logic [PW-1:0]             best_pid_q, best_pid_d;
  logic [TIME_WIDTH-1:0]     best_arr_q, best_arr_d;
  logic [PRIORITY_WIDTH-1:0] best_prio_q, best_prio_d;
  logic [TIME_WIDTH-1:0]     best_rem_q, best_rem_d;

  // finished result waiting for the output register
  logic [PW-1:0] res_id_q, res_id_d;
  logic          res_valid_q, res_valid_d;
  logic          res_empty_q, res_empty_d;
  logic          res_ovf_q, res_ovf_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  logic [PW-1:0] out_id_q;
  logic          out_cv_q, out_empty_q, out_ovf_q;
  logic [CW-1:0] out_held_q;

  // entry ram port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  // fields of the entry just read
  logic [PW-1:0]             rd_pid;
  logic [TIME_WIDTH-1:0]     rd_arr;
  logic [PRIORITY_WIDTH-1:0] rd_prio;
  logic [TIME_WIDTH-1:0]     rd_rem;

  logic          accept;
  logic          last_entry;
  logic          better;
  logic          take;
  logic [AW-1:0] cand_idx;
  logic [PW-1:0] cand_pid;

  assign rd_pid  = ram_rdata[EW-1 -: PW];
  assign rd_arr  = ram_rdata[2*TIME_WIDTH+PRIORITY_WIDTH-1 -: TIME_WIDTH];
  assign rd_prio = ram_rdata[TIME_WIDTH+PRIORITY_WIDTH-1 -: PRIORITY_WIDTH];
  assign rd_rem  = ram_rdata[TIME_WIDTH-1:0];

  // new words only while the sequencer is idle
  assign req_i.ready = (state_q == mpq_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // the entry arriving now is the last one held
  assign last_entry = ((CW'(idx_q) + CW'(1)) == count_q);

  // policy comparison against the best so far; ties keep the earlier slot
  always_comb begin
    unique case (policy_q)
      mpq_pkg::POL_ROUND_ROBIN: better = 1'b0;
      mpq_pkg::POL_FCFS:        better = rd_arr < best_arr_q;
      mpq_pkg::POL_PRIORITY:    better = rd_prio > best_prio_q;
      mpq_pkg::POL_SHORTEST:    better = rd_rem < best_rem_q;
      default:                  better = 1'b0;
    endcase
  end

  // the head entry always starts as the best
  assign take     = (idx_q == '0) || better;
  assign cand_idx = take ? idx_q : best_idx_q;
  assign cand_pid = take ? rd_pid : best_pid_q;

  // sequencer: enqueue writes the tail, dispatch scans then shifts later entries down.
  // the shift reads slot k+1 while writing slot k-1, so read and write never meet
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_pid_d  = best_pid_q;
    best_arr_d  = best_arr_q;
    best_prio_d = best_prio_q;
    best_rem_d  = best_rem_q;
    res_id_d    = res_id_q;
    res_valid_d = res_valid_q;
    res_empty_d = res_empty_q;
    res_ovf_d   = res_ovf_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q - AW'(1);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_q + AW'(1);
    out_load    = 1'b0;

    unique case (state_q)
      mpq_pkg::ST_IDLE: begin
        if (accept) begin
          res_id_d    = '0;
          res_valid_d = 1'b0;
          res_empty_d = 1'b0;
          res_ovf_d   = 1'b0;
          state_d     = mpq_pkg::ST_DONE;
          if (req_i.op == mpq_pkg::OP_DISPATCH) begin
            if (count_q == '0) begin
              res_empty_d = 1'b1;
            end else begin
              // fetch the head entry and start the scan
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_d     = '0;
              state_d   = mpq_pkg::ST_SCAN;
            end
          end else if (count_q == CW'(QUEUE_DEPTH)) begin
            res_ovf_d = 1'b1;
          end else begin
            // append at the tail
            ram_we    = 1'b1;
            ram_waddr = count_q[AW-1:0];
            ram_wdata = {req_i.process_id, req_i.arrival_tick,
                         req_i.priority_level, req_i.run_ticks};
            count_d   = count_q + CW'(1);
          end
        end
      end

      mpq_pkg::ST_SCAN: begin
        best_idx_d = cand_idx;
        best_pid_d = cand_pid;
        if (take) begin
          best_arr_d  = rd_arr;
          best_prio_d = rd_prio;
          best_rem_d  = rd_rem;
        end
        if (last_entry) begin
          res_id_d    = cand_pid;
          res_valid_d = 1'b1;
          if (cand_idx == idx_q) begin
            // tail entry taken, nothing to compact
            count_d = count_q - CW'(1);
            state_d = mpq_pkg::ST_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cand_idx + AW'(1);
            idx_d     = cand_idx + AW'(1);
            state_d   = mpq_pkg::ST_SHIFT;
          end
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_q + AW'(1);
        end
      end

      mpq_pkg::ST_SHIFT: begin
        // move the entry just read one place towards the head
        ram_we = 1'b1;
        if (last_entry) begin
          count_d = count_q - CW'(1);
          state_d = mpq_pkg::ST_DONE;
        end else begin
          ram_re = 1'b1;
          idx_d  = idx_q + AW'(1);
        end
      end

      mpq_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = mpq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = mpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !rsp_o.ready);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpq_pkg::ST_IDLE;
      count_q     <= '0;
      policy_q    <= mpq_pkg::POL_ROUND_ROBIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        policy_q <= mpq_pkg::policy_e'(cfg_wdata_i);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    best_idx_q  <= best_idx_d;
    best_pid_q  <= best_pid_d;
    best_arr_q  <= best_arr_d;
    best_prio_q <= best_prio_d;
    best_rem_q  <= best_rem_d;
    res_id_q    <= res_id_d;
    res_valid_q <= res_valid_d;
    res_empty_q <= res_empty_d;
    res_ovf_q   <= res_ovf_d;
    if (out_load) begin
      out_id_q    <= res_id_q;
      out_cv_q    <= res_valid_q;
      out_empty_q <= res_empty_q;
      out_ovf_q   <= res_ovf_q;
      out_held_q  <= count_q;
    end
  end

  // entry store
  mpq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // response channel
  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.chosen_id      = out_id_q;
  assign rsp_o.chosen_valid   = out_cv_q;
  assign rsp_o.queue_empty    = out_empty_q;
  assign rsp_o.queue_overflow = out_ovf_q;
  assign rsp_o.entries_held   = out_held_q;

endmodule

// ----- rtl/core/mpq_ram.sv -----
// generic single-write, single-read ram with registered read data
module mpq_ram #(
  parameter int unsigned WIDTH = 44,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      store_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= store_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
